// ----- rtl/mmfm_pkg.sv -----
// Shared types and constants for the MDIO clause-22 management frame master.
package mmfm_pkg;

  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned ADDR_W     = 5;
  localparam int unsigned DATA_W     = 16;
  localparam int unsigned FRAME_W    = 32;
  localparam int unsigned CFG_DATA_W = 6;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned POS_W      = 7;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [FUNC_W-1:0] FUNC_START_RD = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_START_WR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TICK     = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRAILER  = 1'b1;
  localparam logic [CFG_DATA_W-1:0] CFG_RESET   = 6'd32;

  localparam logic [FRAME_W-1:0] FRAME_READ  = 32'h6002_0000;
  localparam logic [FRAME_W-1:0] FRAME_WRITE = 32'h5002_0000;
  localparam logic [POS_W-1:0]   FRAME_BITS  = 7'd32;
  localparam logic [POS_W-1:0]   MAX_EDGE    = 7'd32;
  localparam logic [POS_W-1:0]   READ_DRIVEN = 7'd14;

  typedef enum logic [1:0] {
    OP_START_RD,
    OP_START_WR,
    OP_TICK,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [FRAME_W-1:0] frame;
    logic               mdio_in;
  } cmd_t;

endpackage

// ----- rtl/mmfm_req_if.sv -----
// Request channel: one item per beat, valid/ready handshake.
interface mmfm_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [4:0]  phy_addr;
  logic [4:0]  reg_addr;
  logic [15:0] write_data;
  logic        mdio_in;

  modport source (output valid, func, phy_addr, reg_addr, write_data, mdio_in, input ready);
  modport sink (input valid, func, phy_addr, reg_addr, write_data, mdio_in, output ready);
endinterface

// ----- rtl/mmfm_rsp_if.sv -----
// Response channel: one result per beat, valid/ready handshake.
interface mmfm_rsp_if;
  logic        valid;
  logic        ready;
  logic        mdio_out;
  logic        mdio_drive;
  logic        busy_res;
  logic        done_res;
  logic [15:0] read_data;
  logic        accepted;

  modport source (output valid, mdio_out, mdio_drive, busy_res, done_res, read_data, accepted,
                  input ready);
  modport sink (input valid, mdio_out, mdio_drive, busy_res, done_res, read_data, accepted,
                output ready);
endinterface

// ----- rtl/mmfm_front.sv -----
// Front end: accept request beats, classify the function and build the frame word.
module mmfm_front (
  mmfm_req_if.sink       req,
  output logic           push_valid_o,
  input  logic           push_ready_i,
  output mmfm_pkg::cmd_t push_cmd_o
);
  import mmfm_pkg::*;

  logic [FRAME_W-1:0] addr_bits;

  assign req.ready    = push_ready_i;
  assign push_valid_o = req.valid;
  assign addr_bits    = (FRAME_W'(req.phy_addr) << 23) | (FRAME_W'(req.reg_addr) << 18);

  always_comb begin
    push_cmd_o.mdio_in = req.mdio_in;
    push_cmd_o.frame   = '0;
    unique case (req.func)
      FUNC_START_RD: begin
        push_cmd_o.op    = OP_START_RD;
        push_cmd_o.frame = FRAME_READ | addr_bits;
      end
      FUNC_START_WR: begin
        push_cmd_o.op    = OP_START_WR;
        push_cmd_o.frame = FRAME_WRITE | addr_bits | FRAME_W'(req.write_data);
      end
      FUNC_TICK: begin
        push_cmd_o.op = OP_TICK;
      end
      default: begin
        push_cmd_o.op = OP_NOP;
      end
    endcase
  end
endmodule

// ----- rtl/mmfm_queue.sv -----
// Command queue between front and back end.
module mmfm_queue #(
  parameter int unsigned Depth = mmfm_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  mmfm_pkg::cmd_t push_cmd_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output mmfm_pkg::cmd_t pop_cmd_o
);
  import mmfm_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != FullCnt);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_cmd_o    = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end
endmodule

// ----- rtl/mmfm_back.sv -----
// Back end: frame sequencer, read capture and registered result beat.
module mmfm_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                pop_valid_i,
  output logic                                pop_ready_o,
  input  mmfm_pkg::cmd_t                      pop_cmd_i,
  input  logic [mmfm_pkg::CFG_DATA_W-1:0]     preamble_i,
  input  logic [mmfm_pkg::CFG_DATA_W-1:0]     trailer_i,
  mmfm_rsp_if.source                          rsp
);
  import mmfm_pkg::*;

  typedef struct packed {
    logic              mdio_out;
    logic              mdio_drive;
    logic              busy_res;
    logic              done_res;
    logic [DATA_W-1:0] read_data;
    logic              accepted;
  } res_t;

  logic               active_q, active_d;
  logic               reading_q, reading_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [FRAME_W-1:0] frame_q, frame_d;
  logic [DATA_W-1:0]  cap_q, cap_d;
  logic [DATA_W-1:0]  held_q, held_d;
  logic               out_valid_q, out_valid_d;
  res_t               res_q, res_d;

  logic [POS_W-1:0] pre, trl, pre_end, total, pos_inc, k;
  logic             pop;

  assign pop         = pop_valid_i && pop_ready_o;
  assign pop_ready_o = !out_valid_q || rsp.ready;

  assign pre     = (preamble_i > CFG_DATA_W'(MAX_EDGE)) ? MAX_EDGE : POS_W'(preamble_i);
  assign trl     = (trailer_i > CFG_DATA_W'(MAX_EDGE)) ? MAX_EDGE : POS_W'(trailer_i);
  assign pre_end = pre + FRAME_BITS;
  assign total   = pre_end + trl;
  assign pos_inc = pos_q + 1'b1;
  assign k       = pos_q - pre;

  always_comb begin
    active_d  = active_q;
    reading_d = reading_q;
    pos_d     = pos_q;
    frame_d   = frame_q;
    cap_d     = cap_q;
    held_d    = held_q;
    res_d.mdio_out   = 1'b1;
    res_d.mdio_drive = 1'b1;
    res_d.done_res   = 1'b0;
    res_d.accepted   = 1'b0;
    if (pop) begin
      unique case (pop_cmd_i.op)
        OP_START_RD, OP_START_WR: begin
          if (!active_q) begin
            frame_d        = pop_cmd_i.frame;
            reading_d      = (pop_cmd_i.op == OP_START_RD);
            pos_d          = '0;
            cap_d          = '0;
            active_d       = 1'b1;
            res_d.accepted = 1'b1;
          end
        end
        OP_TICK: begin
          if (active_q) begin
            if (pos_q >= pre && pos_q < pre_end) begin
              if (reading_q && k >= READ_DRIVEN) begin
                res_d.mdio_drive = 1'b0;
                cap_d = {cap_q[DATA_W-2:0], pop_cmd_i.mdio_in};
              end else begin
                res_d.mdio_out = frame_q[FRAME_W-1];
                frame_d        = frame_q << 1;
              end
            end
            pos_d = pos_inc;
            if (pos_inc >= total) begin
              if (reading_q) begin
                held_d = cap_d;
              end
              active_d       = 1'b0;
              reading_d      = 1'b0;
              pos_d          = '0;
              res_d.done_res = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
    res_d.busy_res  = active_d;
    res_d.read_data = held_d;
  end

  assign out_valid_d = pop ? 1'b1 : (out_valid_q && !rsp.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      reading_q   <= 1'b0;
      pos_q       <= '0;
      frame_q     <= '0;
      cap_q       <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      reading_q   <= reading_d;
      pos_q       <= pos_d;
      frame_q     <= frame_d;
      cap_q       <= cap_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      res_q <= res_d;
    end
  end

  assign rsp.valid      = out_valid_q;
  assign rsp.mdio_out   = res_q.mdio_out;
  assign rsp.mdio_drive = res_q.mdio_drive;
  assign rsp.busy_res   = res_q.busy_res;
  assign rsp.done_res   = res_q.done_res;
  assign rsp.read_data  = res_q.read_data;
  assign rsp.accepted   = res_q.accepted;

  a_fall_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(active_q) |-> $past(pop) && $past(pop_cmd_i.op == OP_TICK))
    else $error("transaction ended without a tick");

  a_start_sets_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !active_q && (pop_cmd_i.op == OP_START_RD || pop_cmd_i.op == OP_START_WR)
    |=> active_q && pos_q == '0)
    else $error("accepted start did not open a transaction");

  a_no_pop_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !rsp.ready |-> !pop)
    else $error("command taken while result beat stalled");

  a_idle_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> pos_q == '0 && !reading_q)
    else $error("idle sequencer holds stale position");
endmodule

// ----- rtl/mdio_management_frame_master_top.sv -----
// Top level of the MDIO clause-22 management frame master.
//
//   channel  dir  handshake            payload
//   req_if   in   valid/ready          func, phy_addr, reg_addr, write_data, mdio_in
//   rsp_if   out  valid/ready          mdio_out, mdio_drive, busy_res, done_res,
//                                      read_data, accepted
//   cfg      in   cfg_we_i, no wait    cfg_idx_i, cfg_data_i
//
// One request beat per cycle while the queue has room; each beat gives one response beat.
// After its request is accepted, a command is stored in the queue, then passes the
// back end's shift/count update and is held in its result register.
// A queue of QueueDepth commands lets the request side run while responses stall.
// Reset idles the sequencer and sets both preamble and trailer counts to 32.
module mdio_management_frame_master_top #(
  parameter int unsigned QueueDepth = mmfm_pkg::QUEUE_DEPTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  mmfm_req_if.sink                            req_if,
  mmfm_rsp_if.source                          rsp_if,
  input  logic                                cfg_we_i,
  input  logic [mmfm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [mmfm_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import mmfm_pkg::*;

  logic [CFG_DATA_W-1:0] preamble_q, trailer_q;
  logic                  push_valid, push_ready, pop_valid, pop_ready;
  cmd_t                  push_cmd, pop_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      preamble_q <= CFG_RESET;
      trailer_q  <= CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PREAMBLE: preamble_q <= cfg_data_i;
        CFG_TRAILER:  trailer_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  mmfm_front u_front (
    .req          (req_if),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  mmfm_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  mmfm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_cmd_i   (pop_cmd),
    .preamble_i  (preamble_q),
    .trailer_i   (trailer_q),
    .rsp         (rsp_if)
  );
endmodule

// ----- tb/sv/mdio_frame_checker.sv -----
// Checker for the MDIO frame master: predicts each response beat and compares it.
module mdio_frame_checker
  import mmfm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  mmfm_req_if                   req_if,
  mmfm_rsp_if                   rsp_if,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count_o,
  output int                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        mdio_out;
    logic        mdio_drive;
    logic        busy;
    logic        done;
    logic [15:0] read_data;
    logic        accepted;
  } mgmt_beat_t;

  logic [CFG_DATA_W-1:0] preamble_len;
  logic [CFG_DATA_W-1:0] trailer_len;
  logic [POS_W-1:0]      bit_pos;
  logic [FRAME_W-1:0]    frame_sr;
  logic [DATA_W-1:0]     capture_sr;
  logic                  frame_busy;
  logic                  rd_mode;
  logic [DATA_W-1:0]     last_read;

  mgmt_beat_t beat_q[$];
  mgmt_beat_t want;
  int         errs;

  assign fail_count_o = errs;

  initial errs = 0;

  function automatic mgmt_beat_t next_beat(input logic [1:0] func, input logic [4:0] pa,
                                           input logic [4:0] ra, input logic [15:0] wd,
                                           input logic din);
    mgmt_beat_t b;
    logic [POS_W-1:0] lead;
    logic [POS_W-1:0] total;
    logic [POS_W-1:0] k;
    b = '{mdio_out: 1'b1, mdio_drive: 1'b1, busy: 1'b0, done: 1'b0, read_data: '0,
          accepted: 1'b0};
    if (func == FUNC_START_RD || func == FUNC_START_WR) begin
      if (!frame_busy) begin
        frame_sr = ((func == FUNC_START_RD) ? FRAME_READ : FRAME_WRITE) | {4'b0, pa, ra, 18'b0};
        if (func == FUNC_START_WR) begin
          frame_sr[15:0] = wd;
        end
        rd_mode    = (func == FUNC_START_RD);
        bit_pos    = '0;
        capture_sr = '0;
        frame_busy = 1'b1;
        b.accepted = 1'b1;
      end
    end else if (func == FUNC_TICK && frame_busy) begin
      lead  = (preamble_len > MAX_EDGE) ? MAX_EDGE : POS_W'(preamble_len);
      total = lead + FRAME_BITS + ((trailer_len > MAX_EDGE) ? MAX_EDGE : POS_W'(trailer_len));
      if (bit_pos >= lead && bit_pos < lead + FRAME_BITS) begin
        k = bit_pos - lead;
        if (rd_mode && k >= READ_DRIVEN) begin
          b.mdio_drive = 1'b0;
          capture_sr   = {capture_sr[14:0], din};
        end else begin
          b.mdio_out = frame_sr[31];
          frame_sr   = frame_sr << 1;
        end
      end
      bit_pos = bit_pos + 1'b1;
      if (bit_pos >= total) begin
        if (rd_mode) begin
          last_read = capture_sr;
        end
        frame_busy = 1'b0;
        rd_mode    = 1'b0;
        bit_pos    = '0;
        b.done     = 1'b1;
      end
    end
    b.busy      = frame_busy;
    b.read_data = last_read;
    return b;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] exp_val,
                                      input logic [15:0] got_val);
    if (exp_val !== got_val) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, got_val);
      errs++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      preamble_len = CFG_RESET;
      trailer_len  = CFG_RESET;
      bit_pos      = '0;
      frame_sr     = '0;
      capture_sr   = '0;
      frame_busy   = 1'b0;
      rd_mode      = 1'b0;
      last_read    = '0;
      beat_q.delete();
      pending_o <= 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (beat_q.size() == 0) begin
          $error("response beat with nothing expected");
          errs++;
        end else begin
          want = beat_q.pop_front();
          check_field("mdio_out", 16'(want.mdio_out), 16'(rsp_if.mdio_out));
          check_field("mdio_drive", 16'(want.mdio_drive), 16'(rsp_if.mdio_drive));
          check_field("busy_res", 16'(want.busy), 16'(rsp_if.busy_res));
          check_field("done_res", 16'(want.done), 16'(rsp_if.done_res));
          check_field("read_data", want.read_data, rsp_if.read_data);
          check_field("accepted", 16'(want.accepted), 16'(rsp_if.accepted));
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_PREAMBLE) begin
          preamble_len = cfg_data_i;
        end else begin
          trailer_len = cfg_data_i;
        end
      end
      if (req_if.valid && req_if.ready) begin
        beat_q.push_back(next_beat(req_if.func, req_if.phy_addr, req_if.reg_addr,
                                   req_if.write_data, req_if.mdio_in));
      end
      pending_o <= beat_q.size();
    end
  end

endmodule

// ----- tb/sv/tb_mdio_management_frame_master_top.sv -----
// Testbench top for the MDIO frame master: drives requests, register writes and response stalls.
module tb_mdio_management_frame_master_top;
  import mmfm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [FUNC_W-1:0] FUNC_NOP = FUNC_W'(OP_NOP);
  localparam int WATCHDOG_LIMIT = 2000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending;
  int                    quiet_cycles;
  int                    sent;
  int                    cur_pre;
  int                    cur_trl;
  bit                    no_gaps;

  mmfm_req_if req_if();
  mmfm_rsp_if rsp_if();

  mdio_management_frame_master_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_if     (req_if),
    .rsp_if     (rsp_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  mdio_frame_checker u_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_if       (req_if),
    .rsp_if       (rsp_if),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #10 clk_i = ~clk_i;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 24);
  endfunction

  function automatic int frame_len();
    int edge_max;
    edge_max = int'(MAX_EDGE);
    return (cur_pre > edge_max ? edge_max : cur_pre) + int'(FRAME_BITS) +
           (cur_trl > edge_max ? edge_max : cur_trl);
  endfunction

  task automatic send_item(input logic [1:0] func, input logic [4:0] pa, input logic [4:0] ra,
                           input logic [15:0] wd, input logic din);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.func       <= func;
    req_if.phy_addr   <= pa;
    req_if.reg_addr   <= ra;
    req_if.write_data <= wd;
    req_if.mdio_in    <= din;
    do @(posedge clk_i); while (!req_if.ready);
    sent++;
  endtask

  task automatic send_random(input logic [1:0] func);
    send_item(func, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
              16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
  endtask

  task automatic tick_run(input int n);
    repeat (n) begin
      send_random(FUNC_TICK);
    end
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic set_regs(input int pre, input int trl);
    drain();
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_PREAMBLE;
    cfg_data <= CFG_DATA_W'(pre);
    @(posedge clk_i);
    cfg_idx  <= CFG_TRAILER;
    cfg_data <= CFG_DATA_W'(trl);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    cur_pre = pre;
    cur_trl = trl;
  endtask

  task automatic run_phase(input int pre, input int trl, input int budget);
    int stop;
    int pick;
    int n;
    int cut;
    set_regs(pre, trl);
    stop = sent + budget;
    while (sent < stop) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        send_random($urandom_range(0, 1) ? FUNC_START_WR : FUNC_START_RD);
        n = frame_len();
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          n = $urandom_range(1, n - 1);
        end else if (pick == 1) begin
          n = n + $urandom_range(1, 3);
        end else if (pick == 2) begin
          cut = $urandom_range(1, n - 1);
          tick_run(cut);
          send_random(FUNC_W'($urandom_range(0, 3)));
          n = n - cut;
        end
        tick_run(n);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_random(FUNC_W'($urandom_range(0, 3)));
        end
      end
    end
  endtask

  initial begin
    rsp_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      int gap;
      rsp_if.ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
      gap = gap_len();
      if (gap > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_mdio_management_frame_master_top: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni            <= 1'b0;
    req_if.valid      <= 1'b0;
    req_if.func       <= FUNC_TICK;
    req_if.phy_addr   <= '0;
    req_if.reg_addr   <= '0;
    req_if.write_data <= '0;
    req_if.mdio_in    <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_idx           <= CFG_PREAMBLE;
    cfg_data          <= '0;
    quiet_cycles      = 0;
    sent              = 0;
    cur_pre           = int'(CFG_RESET);
    cur_trl           = int'(CFG_RESET);
    no_gaps           = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // idle line, unused code, then a write with every field at its top value
    send_item(FUNC_TICK, 5'd0, 5'd0, 16'h0000, 1'b0);
    send_item(FUNC_NOP, 5'd31, 5'd31, 16'hffff, 1'b1);
    send_item(FUNC_START_WR, 5'd31, 5'd31, 16'hffff, 1'b1);
    send_item(FUNC_START_RD, 5'd0, 5'd0, 16'h0000, 1'b0);
    send_item(FUNC_START_WR, 5'd0, 5'd0, 16'h0000, 1'b0);
    send_item(FUNC_NOP, 5'd0, 5'd0, 16'h0000, 1'b0);
    tick_run(40);
    // shrink the frame under the running write: it ends on the next beat
    set_regs(0, 0);
    tick_run(1);
    send_item(FUNC_START_RD, 5'd0, 5'd0, 16'h0000, 1'b0);
    tick_run(frame_len() + 1);
    send_item(FUNC_START_WR, 5'd0, 5'd0, 16'h0000, 1'b0);
    tick_run(frame_len());

    run_phase(0, 0, 60);
    run_phase(63, 33, 60);
    run_phase($urandom_range(0, 6), $urandom_range(0, 6), 60);
    run_phase(1, 0, 60);
    run_phase(0, 32, 60);
    run_phase($urandom_range(0, 63), $urandom_range(0, 63), 60);

    drain();
    if (fail_count == 0) begin
      $display("tb_mdio_management_frame_master_top: PASS");
    end else begin
      $display("tb_mdio_management_frame_master_top: FAIL");
    end
    $finish;
  end

endmodule
